@@ rtl/env_sensor_compensation_top_defines.svh @@
// assertion macros shared by the compensation block
`ifndef ENV_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ESC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ESC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESC_ASSERT_IMP(name, ante, cons, msg)
`define ESC_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/esc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the compensation block
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } esc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_out;
    logic [31:0]        press_out;
    logic [16:0]        hum_out;
  } esc_out_t;

  // decoded calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } esc_trim_t;

  typedef enum logic [2:0] {
    REG_TEMP_TRIM    = 3'd0,
    REG_PRESS_TRIM_A = 3'd1,
    REG_PRESS_TRIM_B = 3'd2,
    REG_PRESS_TRIM_C = 3'd3,
    REG_HUM_TRIM_A   = 3'd4,
    REG_HUM_TRIM_B   = 3'd5
  } esc_reg_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;

  // pipeline latencies in register stages
  localparam int unsigned FineLat   = 3;   // input register to fine temperature
  localparam int unsigned TempLat   = 4;   // input register to temperature result
  localparam int unsigned HumLat    = 7;   // fine temperature to humidity result
  localparam int unsigned DivLat    = 66;  // divider, prepare + 64 bit steps + sign fix
  localparam int unsigned PressLat  = 6 + DivLat + 4;
  localparam int unsigned LastStage = FineLat + PressLat;

  localparam logic [31:0] HumMax    = 32'd419430400;

endpackage

@@ rtl/esc_dly.sv @@
`timescale 1ns / 1ps
// enabled shift line for payload alignment
module esc_dly #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

@@ rtl/esc_temp.sv @@
`timescale 1ns / 1ps
// temperature pipeline: fine temperature and 0.01 degc result
module esc_temp
  import esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [19:0] raw_temp_i,
  input  esc_trim_t   trim_i,
  output logic [31:0] fine_o,
  output logic [31:0] tc_o
);

  logic [31:0] t2x, t3x, dx1, dt;
  logic [31:0] m1_d, m1_q, dd_d, dd_q;
  logic [31:0] x1_d, x1_q, m2_d, m2_q, dds;
  logic [31:0] fine_d, fine_q, tmp, tc_d, tc_q;

  assign t2x = {{16{trim_i.t2[15]}}, trim_i.t2};
  assign t3x = {{16{trim_i.t3[15]}}, trim_i.t3};

  always_comb begin
    // stage 1
    dx1  = {15'b0, raw_temp_i[19:3]} - {15'b0, trim_i.t1, 1'b0};
    dt   = {16'b0, raw_temp_i[19:4]} - {16'b0, trim_i.t1};
    m1_d = dx1 * t2x;
    dd_d = dt * dt;
    // stage 2
    x1_d = $signed(m1_q) >>> 11;
    dds  = $signed(dd_q) >>> 12;
    m2_d = dds * t3x;
    // stage 3
    fine_d = x1_q + $unsigned($signed(m2_q) >>> 14);
    // stage 4
    tmp  = fine_q * 32'd5 + 32'd128;
    tc_d = $signed(tmp) >>> 8;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= m1_d;
      dd_q   <= dd_d;
      x1_q   <= x1_d;
      m2_q   <= m2_d;
      fine_q <= fine_d;
      tc_q   <= tc_d;
    end
  end

  assign fine_o = fine_q;
  assign tc_o   = tc_q;

endmodule

@@ rtl/esc_hum.sv @@
`timescale 1ns / 1ps
// humidity pipeline, seven stages from the fine temperature
module esc_hum
  import esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] fine_i,
  input  logic [15:0] raw_hum_i,
  input  esc_trim_t   trim_i,
  output logic [16:0] hum_o
);

  logic [31:0] h1x, h2x, h3x, h5x, h6x;
  logic [31:0] x, m6, m3, v3, v4, s, xf;
  logic [31:0] u1_d, u1_q, p6_d, p6_q, p3_d, p3_q;
  logic [31:0] u2_d, u2_q, v2_d, v2_q;
  logic [31:0] u3_q, vm_d, vm_q;
  logic [31:0] x4_d, x4_q;
  logic [31:0] ss_d, ss_q, x5_q;
  logic [31:0] sm_d, sm_q, x6_q;
  logic [16:0] hum_d, hum_q;

  assign h1x = {24'b0, trim_i.h1};
  assign h2x = {{16{trim_i.h2[15]}}, trim_i.h2};
  assign h3x = {24'b0, trim_i.h3};
  assign h5x = {{16{trim_i.h5[15]}}, trim_i.h5};
  assign h6x = {{24{trim_i.h6[7]}}, trim_i.h6};

  always_comb begin
    x    = fine_i - 32'd76800;
    u1_d = {2'b0, raw_hum_i, 14'b0} - {trim_i.h4[11:0], 20'b0} - h5x * x;
    m6   = x * h6x;
    m3   = x * h3x;
    p6_d = $signed(m6) >>> 10;
    p3_d = $unsigned($signed(m3) >>> 11) + 32'd32768;

    u2_d = $signed(u1_q + 32'd16384) >>> 15;
    v2_d = p6_q * p3_q;

    v3   = $unsigned($signed(v2_q) >>> 10) + 32'd2097152;
    vm_d = v3 * h2x;

    v4   = $signed(vm_q + 32'd8192) >>> 14;
    x4_d = u3_q * v4;

    s    = $signed(x4_q) >>> 15;
    ss_d = s * s;

    sm_d = $unsigned($signed(ss_q) >>> 7) * h1x;

    // clamp to 0..100 %rh before the final shift
    xf = x6_q - $unsigned($signed(sm_q) >>> 4);
    if (xf[31]) begin
      xf = '0;
    end else if (xf > HumMax) begin
      xf = HumMax;
    end
    hum_d = xf[28:12];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q  <= u1_d;
      p6_q  <= p6_d;
      p3_q  <= p3_d;
      u2_q  <= u2_d;
      v2_q  <= v2_d;
      u3_q  <= u2_q;
      vm_q  <= vm_d;
      x4_q  <= x4_d;
      ss_q  <= ss_d;
      x5_q  <= x4_q;
      sm_q  <= sm_d;
      x6_q  <= x5_q;
      hum_q <= hum_d;
    end
  end

  assign hum_o = hum_q;

endmodule

@@ rtl/esc_pdiv.sv @@
`timescale 1ns / 1ps
// pipelined signed 64-bit divider, one quotient bit per stage
module esc_pdiv (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o,
  output logic        zero_o
);

  localparam int unsigned Steps = 64;

  logic [63:0] rem_q [Steps+1];
  logic [63:0] quo_q [Steps+1];
  logic [63:0] den_q [Steps+1];
  logic        neg_q [Steps+1];
  logic        zero_q [Steps+1];
  logic [63:0] res_q;
  logic        zres_q;

  // prepare magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      quo_q[0]  <= num_i[63] ? 64'd0 - num_i : num_i;
      den_q[0]  <= den_i[63] ? 64'd0 - den_i : den_i;
      neg_q[0]  <= num_i[63] ^ den_i[63];
      zero_q[0] <= (den_i == 64'd0);
    end
  end

  for (genvar g = 1; g <= Steps; g++) begin : g_step
    logic [64:0] rs, diff;
    always_comb begin
      rs   = {rem_q[g-1], quo_q[g-1][63]};
      diff = rs - {1'b0, den_q[g-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= diff[64] ? rs[63:0] : diff[63:0];
        quo_q[g]  <= {quo_q[g-1][62:0], ~diff[64]};
        den_q[g]  <= den_q[g-1];
        neg_q[g]  <= neg_q[g-1];
        zero_q[g] <= zero_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= neg_q[Steps] ? 64'd0 - quo_q[Steps] : quo_q[Steps];
      zres_q <= zero_q[Steps];
    end
  end

  assign quo_o  = res_q;
  assign zero_o = zres_q;

endmodule

@@ rtl/esc_press.sv @@
`timescale 1ns / 1ps
// pressure pipeline: divisor and dividend, divider, final terms
module esc_press
  import esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] fine_i,
  input  logic [19:0] raw_press_i,
  input  esc_trim_t   trim_i,
  output logic [31:0] press_o
);

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx49(input logic [48:0] v);
    return {{15{v[48]}}, v};
  endfunction

  // low word times signed 16-bit, exact
  function automatic logic [48:0] mlo(input logic [31:0] x, input logic [15:0] y);
    logic signed [48:0] r;
    r = $signed({1'b0, x}) * $signed(y);
    return r;
  endfunction

  // high word times signed 16-bit, low 32 bits only
  function automatic logic [31:0] mhi(input logic [31:0] x, input logic [15:0] y);
    return x * {{16{y[15]}}, y};
  endfunction

  // stage 1
  logic signed [32:0] a1_d, a1_q;
  logic signed [65:0] aa_full;
  logic [63:0]        aa_q;
  logic [19:0]        ap1_q, ap2_q, ap3_q;
  // stage 2
  logic [48:0] b6lo_q, b3lo_q;
  logic [31:0] b6hi_q, b3hi_q;
  logic signed [48:0] ap5_d, ap5_q, ap2m_d, ap2m_q;
  // stage 3
  logic [63:0] b6, b3, b_d, b_q, a2_d, a2_q;
  // stage 4
  logic [63:0] t, q0, n_d, n_q;
  logic [47:0] tlo_d, tlo_q;
  logic [31:0] thi_d, thi_q;
  // stage 5
  logic [63:0] den_d, den_q;
  logic [43:0] nlo_d, nlo_q;
  logic [31:0] nhi_d, nhi_q;
  // stage 6
  logic [63:0] num_q, den2_q;
  // divider
  logic [63:0] quo;
  logic        zero;
  // final stages
  logic [63:0] qs, ll_q, sq_q, s8, c8_q, c8b_q, q1_q, q2_q, q3_q, s9, tot, pr;
  logic [31:0] lh_q, q8hi_q, s9hi_q;
  logic [48:0] q8lo_q, s9lo_q;
  logic        z1_q, z2_q, z3_q;
  logic [31:0] press_d, press_q;

  always_comb begin
    a1_d    = $signed({fine_i[31], fine_i}) - 33'sd128000;
    aa_full = a1_d * a1_d;
    ap5_d   = a1_q * $signed(trim_i.p5);
    ap2m_d  = a1_q * $signed(trim_i.p2);

    b6  = sx49(b6lo_q) + {b6hi_q, 32'b0};
    b_d = b6 + (sx49(ap5_q) << 17) + (sx16(trim_i.p4) << 35);
    b3  = sx49(b3lo_q) + {b3hi_q, 32'b0};
    a2_d = $unsigned($signed(b3) >>> 8) + (sx49(ap2m_q) << 12);

    t     = 64'h0000_8000_0000_0000 + a2_q;
    tlo_d = t[31:0] * trim_i.p1;
    thi_d = t[63:32] * {16'b0, trim_i.p1};
    q0    = 64'd1048576 - {44'b0, ap3_q};
    n_d   = {q0[32:0], 31'b0} - b_q;

    den_d = $signed({thi_q, 32'b0} + {16'b0, tlo_q}) >>> 33;
    nlo_d = n_q[31:0] * 12'd3125;
    nhi_d = n_q[63:32] * 32'd3125;

    qs = $signed(quo) >>> 13;

    s8 = sx49(q8lo_q) + {q8hi_q, 32'b0};
    s9 = sx49(s9lo_q) + {s9hi_q, 32'b0};
    tot = q3_q + $unsigned($signed(s9) >>> 25) + c8b_q;
    pr  = $unsigned($signed(tot) >>> 8) + (sx16(trim_i.p7) << 4);
    press_d = z3_q ? 32'd0 : pr[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a1_d;
      aa_q   <= aa_full[63:0];
      ap1_q  <= raw_press_i;

      b6lo_q <= mlo(aa_q[31:0], trim_i.p6);
      b6hi_q <= mhi(aa_q[63:32], trim_i.p6);
      b3lo_q <= mlo(aa_q[31:0], trim_i.p3);
      b3hi_q <= mhi(aa_q[63:32], trim_i.p3);
      ap5_q  <= ap5_d;
      ap2m_q <= ap2m_d;
      ap2_q  <= ap1_q;

      b_q    <= b_d;
      a2_q   <= a2_d;
      ap3_q  <= ap2_q;

      tlo_q  <= tlo_d;
      thi_q  <= thi_d;
      n_q    <= n_d;

      den_q  <= den_d;
      nlo_q  <= nlo_d;
      nhi_q  <= nhi_d;

      num_q  <= {nhi_q, 32'b0} + {20'b0, nlo_q};
      den2_q <= den_q;

      ll_q   <= qs[31:0] * qs[31:0];
      lh_q   <= qs[31:0] * qs[63:32];
      q8lo_q <= mlo(quo[31:0], trim_i.p8);
      q8hi_q <= mhi(quo[63:32], trim_i.p8);
      q1_q   <= quo;
      z1_q   <= zero;

      sq_q   <= ll_q + {lh_q[30:0], 1'b0, 32'b0};
      c8_q   <= $signed(s8) >>> 19;
      q2_q   <= q1_q;
      z2_q   <= z1_q;

      s9lo_q <= mlo(sq_q[31:0], trim_i.p9);
      s9hi_q <= mhi(sq_q[63:32], trim_i.p9);
      c8b_q  <= c8_q;
      q3_q   <= q2_q;
      z3_q   <= z2_q;

      press_q <= press_d;
    end
  end

  esc_pdiv u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num_q),
    .den_i  (den2_q),
    .quo_o  (quo),
    .zero_o (zero)
  );

  assign press_o = press_q;

endmodule

@@ rtl/env_sensor_compensation_top.sv @@
`timescale 1ns / 1ps
// top level of the temperature, pressure and humidity compensation block
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid_i / in_stall_o | in_data_i (raw triple)
//   out     | source    | out_valid_o / out_stall_i | out_data_o (compensated)
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle sustained unless the output stalls
// latency is set by the 64-step pipelined divider in the pressure path
// reset clears the calibration registers and the stage valid bits
// a stall on the output freezes every stage at once, so nothing is lost or repeated
// calibration registers feed the pipe; user must write them while idle, unenforced
`include "env_sensor_compensation_top_defines.svh"

module env_sensor_compensation_top
  import esc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  esc_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output esc_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // calibration registers
  logic [47:0] temp_trim_q, press_a_q, press_b_q, press_c_q;
  logic [31:0] hum_a_q;
  logic [39:0] hum_b_q;
  esc_trim_t   trim;

  // pipeline control: valid bit per stage, one global advance
  logic [LastStage:0] vld_q;
  logic               adv;
  esc_in_t            in_q;

  logic [19:0] raw_press_d3;
  logic [15:0] raw_hum_d3;
  logic [31:0] fine, tc, tc_al, press;
  logic [16:0] hum, hum_al;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      press_a_q   <= '0;
      press_b_q   <= '0;
      press_c_q   <= '0;
      hum_a_q     <= '0;
      hum_b_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (esc_reg_e'(cfg_index_i))
        REG_TEMP_TRIM:    temp_trim_q <= cfg_data_i;
        REG_PRESS_TRIM_A: press_a_q   <= cfg_data_i;
        REG_PRESS_TRIM_B: press_b_q   <= cfg_data_i;
        REG_PRESS_TRIM_C: press_c_q   <= cfg_data_i;
        REG_HUM_TRIM_A:   hum_a_q     <= cfg_data_i[31:0];
        REG_HUM_TRIM_B:   hum_b_q     <= cfg_data_i[39:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // unpack calibration words
  assign trim.t1 = temp_trim_q[47:32];
  assign trim.t2 = temp_trim_q[31:16];
  assign trim.t3 = temp_trim_q[15:0];
  assign trim.p1 = press_a_q[47:32];
  assign trim.p2 = press_a_q[31:16];
  assign trim.p3 = press_a_q[15:0];
  assign trim.p4 = press_b_q[47:32];
  assign trim.p5 = press_b_q[31:16];
  assign trim.p6 = press_b_q[15:0];
  assign trim.p7 = press_c_q[47:32];
  assign trim.p8 = press_c_q[31:16];
  assign trim.p9 = press_c_q[15:0];
  assign trim.h1 = hum_a_q[31:24];
  assign trim.h2 = hum_a_q[23:8];
  assign trim.h3 = hum_a_q[7:0];
  assign trim.h4 = hum_b_q[39:24];
  assign trim.h5 = hum_b_q[23:8];
  assign trim.h6 = hum_b_q[7:0];

  // whole pipe holds while a finished item waits at the output
  assign adv        = !(vld_q[LastStage] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LastStage-1:0], in_valid_i};
    end
  end

  // input register, stage 0
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  esc_temp u_temp (
    .clk_i      (clk_i),
    .en_i       (adv),
    .raw_temp_i (in_q.raw_temp),
    .trim_i     (trim),
    .fine_o     (fine),
    .tc_o       (tc)
  );

  // raw pressure and humidity wait for the fine temperature
  esc_dly #(.WIDTH(20), .DEPTH(FineLat)) u_dly_press (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (in_q.raw_press),
    .q_o   (raw_press_d3)
  );

  esc_dly #(.WIDTH(16), .DEPTH(FineLat)) u_dly_hum (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (in_q.raw_hum),
    .q_o   (raw_hum_d3)
  );

  esc_press u_press (
    .clk_i       (clk_i),
    .en_i        (adv),
    .fine_i      (fine),
    .raw_press_i (raw_press_d3),
    .trim_i      (trim),
    .press_o     (press)
  );

  esc_hum u_hum (
    .clk_i     (clk_i),
    .en_i      (adv),
    .fine_i    (fine),
    .raw_hum_i (raw_hum_d3),
    .trim_i    (trim),
    .hum_o     (hum)
  );

  // temperature and humidity line up with the slower pressure result
  esc_dly #(.WIDTH(32), .DEPTH(LastStage - TempLat)) u_dly_tc (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (tc),
    .q_o   (tc_al)
  );

  esc_dly #(.WIDTH(17), .DEPTH(LastStage - FineLat - HumLat)) u_dly_hout (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (hum),
    .q_o   (hum_al)
  );

  assign out_valid_o          = vld_q[LastStage];
  assign out_data_o.temp_out  = tc_al;
  assign out_data_o.press_out = press;
  assign out_data_o.hum_out   = hum_al;

  `ESC_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "stall without waiting item")
  `ESC_ASSERT_NXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0], "accepted item not in stage 0")
  `ESC_ASSERT_NXT(a_pipe_frozen, in_stall_o, $stable(vld_q), "valid bits moved during stall")
  `ESC_ASSERT_IMP(a_hum_range, out_valid_o, out_data_o.hum_out <= 17'd102400, "humidity out of range")

endmodule
